// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ATC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ATC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/atc_pkg.sv
// ----------------------------------------------------------------------------
// atc_pkg
// Shared widths, register indexes, arithmetic constants and the
// request/result structs of the activity totals accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package atc_pkg;

  localparam int unsigned TICKS_PER_MINUTE = 6;

  localparam int unsigned STEPS_W      = 24;
  localparam int unsigned DIST_W       = 25;
  localparam int unsigned TOTAL_W      = 32;
  localparam int unsigned USER_W       = 8;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned ADDR_W       = 5;
  localparam int unsigned REG_IDX_W    = 3;
  localparam int unsigned ACT_KCAL_W   = 10;
  localparam int unsigned BASAL_KCAL_W = 12;
  localparam int unsigned COEF_W       = 15;

  localparam logic [REG_IDX_W-1:0] REG_HEIGHT    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WEIGHT    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_AGE       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SEX       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BASAL_EN  = 3'd4;

  // stride = h*f/1000, f = 415 or 413
  localparam logic [31:0] STRIDE_F0   = 32'd415;
  localparam logic [31:0] STRIDE_F1   = 32'd413;

  // floor(x/D) = (x*RECIP) >> SHIFT over the operand ranges used here
  localparam logic [31:0] RECIP_1000  = 32'd134218;
  localparam int unsigned SHIFT_1000  = 27;
  localparam logic [31:0] RECIP_100   = 32'd2748779070;
  localparam int unsigned SHIFT_100   = 38;
  localparam logic [31:0] RECIP_10000 = 32'd6871948;
  localparam int unsigned SHIFT_10000 = 36;

  localparam logic [31:0] KCAL_WEIGHT = 32'd176;

  localparam logic [31:0] BASAL_H     = 32'd889;
  localparam logic [31:0] BASAL_W     = 32'd14;
  localparam logic [31:0] BASAL_AGE   = 32'd699;
  localparam logic [31:0] BASAL_OFS   = 32'd1414;
  localparam int unsigned BASAL_SHIFT = 10;
  localparam logic [31:0] BASAL_SEX   = 32'd23;
  localparam logic [31:0] BASAL_MUL   = 32'd5;
  localparam logic [31:0] BASAL_CAP   = 32'd3700;

  typedef struct packed {
    logic [STEPS_W-1:0] now;
    logic [STEPS_W-1:0] prev_minute;
    logic [USER_W-1:0]  height;
    logic [USER_W-1:0]  weight;
    logic [USER_W-1:0]  age;
    logic               sex;
  } calc_req_t;

  typedef struct packed {
    logic [DIST_W-1:0]       distance;
    logic [ACT_KCAL_W-1:0]   act;
    logic [BASAL_KCAL_W-1:0] basal;
  } calc_res_t;

  // 176 * tier factor for the steps taken in one minute
  function automatic logic [COEF_W-1:0] act_coef(input logic [STEPS_W-1:0] d);
    logic [COEF_W-1:0] c;
    if (d < 24'd40) begin
      c = COEF_W'(KCAL_WEIGHT * 1);
    end else if (d < 24'd80) begin
      c = COEF_W'(KCAL_WEIGHT * 15);
    end else if (d < 24'd100) begin
      c = COEF_W'(KCAL_WEIGHT * 20);
    end else if (d < 24'd120) begin
      c = COEF_W'(KCAL_WEIGHT * 35);
    end else if (d < 24'd140) begin
      c = COEF_W'(KCAL_WEIGHT * 55);
    end else if (d < 24'd160) begin
      c = COEF_W'(KCAL_WEIGHT * 80);
    end else if (d < 24'd180) begin
      c = COEF_W'(KCAL_WEIGHT * 110);
    end else begin
      c = COEF_W'(KCAL_WEIGHT * 140);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/atc_stream_if.sv
// ----------------------------------------------------------------------------
// atc_stream_if
// Valid/ready item channels: tick/clear requests in, totals out.
// ----------------------------------------------------------------------------
`default_nettype none

interface atc_req_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [atc_pkg::STEPS_W-1:0] step_total;
  logic                        usb_attached;

  modport source (output valid, func, step_total, usb_attached, input ready);
  modport sink   (input valid, func, step_total, usb_attached, output ready);
endinterface

interface atc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [atc_pkg::STEPS_W-1:0] shown_steps;
  logic [atc_pkg::DIST_W-1:0]  distance;
  logic [atc_pkg::TOTAL_W-1:0] active_minutes;
  logic [atc_pkg::TOTAL_W-1:0] energy;
  logic                        goal_check;

  modport source (output valid, shown_steps, distance, active_minutes, energy,
                  goal_check, input ready);
  modport sink   (input valid, shown_steps, distance, active_minutes, energy,
                  goal_check, output ready);
endinterface

`default_nettype wire

// File: rtl/core/atc_calc.sv
// ----------------------------------------------------------------------------
// atc_calc
// Twelve-step sequencer around one registered 32x32 multiplier: distance,
// per-minute activity kcal and capped basal kcal for one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module atc_calc (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  atc_pkg::calc_req_t req,
  output logic               done,
  output atc_pkg::calc_res_t res
);

  localparam int unsigned STEP_W        = 4;
  localparam int unsigned STRIDE_W      = 7;
  localparam int unsigned STRIDE_PROD_W = 17;
  localparam int unsigned DIST_PROD_W   = 31;
  localparam int unsigned ACT_PROD_W    = 23;

  localparam logic [STEP_W-1:0] STEP_STRIDE_MUL = 4'd0;
  localparam logic [STEP_W-1:0] STEP_STRIDE_DIV = 4'd1;
  localparam logic [STEP_W-1:0] STEP_DIST_MUL   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_DIST_DIV   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_ACT_MUL    = 4'd4;
  localparam logic [STEP_W-1:0] STEP_ACT_DIV    = 4'd5;
  localparam logic [STEP_W-1:0] STEP_BAS_H      = 4'd6;
  localparam logic [STEP_W-1:0] STEP_BAS_W      = 4'd7;
  localparam logic [STEP_W-1:0] STEP_BAS_AGE    = 4'd8;
  localparam logic [STEP_W-1:0] STEP_BAS_SUB    = 4'd9;
  localparam logic [STEP_W-1:0] STEP_BAS_SCALE  = 4'd10;
  localparam logic [STEP_W-1:0] STEP_BAS_CAP    = 4'd11;

  logic                      busy;
  logic [STEP_W-1:0]         step;
  logic [63:0]               prod;
  logic [31:0]               acc;
  logic [31:0]               op_a;
  logic [31:0]               op_b;
  logic [atc_pkg::STEPS_W-1:0] d;

  assign d = req.now - req.prev_minute;

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (step)
      STEP_STRIDE_MUL: begin
        op_a = 32'(req.height);
        op_b = req.sex ? atc_pkg::STRIDE_F1 : atc_pkg::STRIDE_F0;
      end
      STEP_STRIDE_DIV: begin
        op_a = 32'(prod[STRIDE_PROD_W-1:0]);
        op_b = atc_pkg::RECIP_1000;
      end
      STEP_DIST_MUL: begin
        op_a = 32'(req.now);
        op_b = 32'(prod[atc_pkg::SHIFT_1000 +: STRIDE_W]);
      end
      STEP_DIST_DIV: begin
        op_a = 32'(prod[DIST_PROD_W-1:0]);
        op_b = atc_pkg::RECIP_100;
      end
      STEP_ACT_MUL: begin
        op_a = 32'(req.weight);
        op_b = 32'(atc_pkg::act_coef(d));
      end
      STEP_ACT_DIV: begin
        op_a = 32'(prod[ACT_PROD_W-1:0]);
        op_b = atc_pkg::RECIP_10000;
      end
      STEP_BAS_H: begin
        op_a = 32'(req.height);
        op_b = atc_pkg::BASAL_H;
      end
      STEP_BAS_W: begin
        op_a = 32'(req.weight);
        op_b = atc_pkg::BASAL_W;
      end
      STEP_BAS_AGE: begin
        op_a = 32'(req.age);
        op_b = atc_pkg::BASAL_AGE;
      end
      STEP_BAS_SCALE: begin
        op_a = (acc >> atc_pkg::BASAL_SHIFT) - (req.sex ? atc_pkg::BASAL_SEX : 32'd0);
        op_b = atc_pkg::BASAL_MUL;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_BAS_CAP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  // product of the previous step is consumed while the next one is issued
  always_ff @(posedge clk) begin
    prod <= 64'(op_a) * 64'(op_b);
    if (busy) begin
      case (step)
        STEP_ACT_MUL: res.distance <= prod[atc_pkg::SHIFT_100 +: atc_pkg::DIST_W];
        STEP_BAS_H:   res.act      <= prod[atc_pkg::SHIFT_10000 +: atc_pkg::ACT_KCAL_W];
        STEP_BAS_W:   acc          <= prod[31:0] + atc_pkg::BASAL_OFS;
        STEP_BAS_AGE: acc          <= acc + prod[31:0];
        STEP_BAS_SUB: acc          <= acc - prod[31:0];
        STEP_BAS_CAP: res.basal    <= (prod[31:0] > atc_pkg::BASAL_CAP) ?
                                      atc_pkg::BASAL_KCAL_W'(atc_pkg::BASAL_CAP) :
                                      prod[atc_pkg::BASAL_KCAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/activity_totals_accumulator_core.sv
// ----------------------------------------------------------------------------
// activity_totals_accumulator_core
// Tick item: result valid after the 12-step pass through the shared multiplier
// in atc_calc. Clear item: skips atc_calc and is presented from the done state.
// Neither kind is accepted until the previous result has been committed.
// Synchronous reset clears registers, totals and tracking state.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module activity_totals_accumulator_core #(
  parameter int unsigned TICKS_PER_MINUTE = atc_pkg::TICKS_PER_MINUTE
) (
  input  logic                       clk,
  input  logic                       rst,
  atc_req_if.sink                    req,
  atc_rsp_if.source                  rsp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [atc_pkg::ADDR_W-1:0] paddr,
  input  logic [atc_pkg::DATA_W-1:0] pwdata,
  output logic [atc_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int unsigned CNT_W = $clog2(TICKS_PER_MINUTE + 1);
  localparam logic [CNT_W-1:0] LAST_TICK = CNT_W'(TICKS_PER_MINUTE - 1);
  localparam logic [1:0] THIRDS_LAST = 2'd2;  // 40 s banked

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state;

  logic [atc_pkg::USER_W-1:0] user_height;
  logic [atc_pkg::USER_W-1:0] user_weight;
  logic [atc_pkg::USER_W-1:0] user_age;
  logic                       user_sex;
  logic                       basal_enable;

  logic                        item_func;
  logic [atc_pkg::STEPS_W-1:0] item_now;
  logic                        item_usb;

  logic [atc_pkg::STEPS_W-1:0] prev_tick;
  logic [atc_pkg::STEPS_W-1:0] prev_pair;
  logic [atc_pkg::STEPS_W-1:0] prev_minute;
  logic [CNT_W-1:0]            minute_cnt;
  logic                        phase;
  logic [1:0]                  thirds;
  logic [atc_pkg::STEPS_W-1:0] steps_reg;
  logic [atc_pkg::DIST_W-1:0]  distance_reg;
  logic [atc_pkg::TOTAL_W-1:0] minutes_reg;
  logic [atc_pkg::TOTAL_W-1:0] energy_reg;
  logic                        goal;
  logic                        out_valid;

  logic                      accept;
  logic                      commit;
  logic                      calc_done;
  atc_pkg::calc_req_t        calc_req;
  atc_pkg::calc_res_t        calc_res;
  logic [atc_pkg::REG_IDX_W-1:0] reg_idx;
  logic                      cfg_wr;

  logic        changed;
  logic        pair_chk;
  logic        pair_rise;
  logic        minute_end;
  logic        act_on;
  logic        bas_on;
  logic        minute_up;
  logic [12:0] kcal_inc;
  logic        goal_next;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[atc_pkg::ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      atc_pkg::REG_HEIGHT:   prdata = atc_pkg::DATA_W'(user_height);
      atc_pkg::REG_WEIGHT:   prdata = atc_pkg::DATA_W'(user_weight);
      atc_pkg::REG_AGE:      prdata = atc_pkg::DATA_W'(user_age);
      atc_pkg::REG_SEX:      prdata = atc_pkg::DATA_W'(user_sex);
      atc_pkg::REG_BASAL_EN: prdata = atc_pkg::DATA_W'(basal_enable);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      user_height  <= '0;
      user_weight  <= '0;
      user_age     <= '0;
      user_sex     <= 1'b0;
      basal_enable <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        atc_pkg::REG_HEIGHT:   user_height  <= pwdata[atc_pkg::USER_W-1:0];
        atc_pkg::REG_WEIGHT:   user_weight  <= pwdata[atc_pkg::USER_W-1:0];
        atc_pkg::REG_AGE:      user_age     <= pwdata[atc_pkg::USER_W-1:0];
        atc_pkg::REG_SEX:      user_sex     <= pwdata[0];
        atc_pkg::REG_BASAL_EN: basal_enable <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // handshakes
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign commit    = (state == ST_DONE) && (!out_valid || rsp.ready);

  assign rsp.valid          = out_valid;
  assign rsp.shown_steps    = steps_reg;
  assign rsp.distance       = distance_reg;
  assign rsp.active_minutes = minutes_reg;
  assign rsp.energy         = energy_reg;
  assign rsp.goal_check     = goal;

  assign calc_req.now         = item_now;
  assign calc_req.prev_minute = prev_minute;
  assign calc_req.height      = user_height;
  assign calc_req.weight      = user_weight;
  assign calc_req.age         = user_age;
  assign calc_req.sex         = user_sex;

  atc_calc u_calc (
    .clk   (clk),
    .rst   (rst),
    .start (accept && !req.func),
    .req   (calc_req),
    .done  (calc_done),
    .res   (calc_res)
  );

  // tick update terms
  always_comb begin
    changed    = (item_now != prev_tick);
    pair_chk   = phase;
    pair_rise  = (item_now > prev_pair);
    minute_end = (minute_cnt == LAST_TICK);
    act_on     = (item_now > prev_minute);
    bas_on     = basal_enable && !item_usb;
    minute_up  = pair_chk && pair_rise && (thirds == THIRDS_LAST);
    kcal_inc   = (act_on ? 13'(calc_res.act) : 13'd0) +
                 (bas_on ? 13'(calc_res.basal) : 13'd0);
    goal_next  = changed || minute_up || (minute_end && (act_on || bas_on));
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_func <= req.func;
      item_now  <= req.step_total;
      item_usb  <= req.usb_attached;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      prev_tick    <= '0;
      prev_pair    <= '0;
      prev_minute  <= '0;
      minute_cnt   <= '0;
      phase        <= 1'b0;
      thirds       <= '0;
      steps_reg    <= '0;
      distance_reg <= '0;
      minutes_reg  <= '0;
      energy_reg   <= '0;
      goal         <= 1'b0;
    end else begin
      if (commit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= req.func ? ST_DONE : ST_BUSY;
          end
        end
        ST_BUSY: begin
          if (calc_done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (commit) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (commit) begin
        if (item_func) begin
          prev_tick    <= '0;
          prev_pair    <= '0;
          prev_minute  <= '0;
          minute_cnt   <= '0;
          phase        <= 1'b0;
          thirds       <= '0;
          steps_reg    <= '0;
          distance_reg <= '0;
          minutes_reg  <= '0;
          energy_reg   <= '0;
          goal         <= 1'b0;
        end else begin
          prev_tick <= item_now;
          phase     <= ~phase;
          goal      <= goal_next;
          if (changed) begin
            steps_reg    <= item_now;
            distance_reg <= calc_res.distance;
          end
          if (pair_chk) begin
            prev_pair <= item_now;
            if (pair_rise) begin
              if (thirds == THIRDS_LAST) begin
                thirds      <= '0;
                minutes_reg <= minutes_reg + 1'b1;
              end else begin
                thirds <= thirds + 1'b1;
              end
            end
          end
          if (minute_end) begin
            minute_cnt  <= '0;
            prev_minute <= item_now;
            energy_reg  <= energy_reg + atc_pkg::TOTAL_W'(kcal_inc);
          end else begin
            minute_cnt <= minute_cnt + 1'b1;
          end
        end
      end
    end
  end

  `ATC_ASSERT_SAME(a_done_in_busy, calc_done, state == ST_BUSY,
                   "calc finished outside busy state")
  `ATC_ASSERT_NEXT(a_commit_shows, commit, rsp.valid,
                   "committed item not presented")
  `ATC_ASSERT_NEXT(a_clear_zeroes, commit && item_func,
                   minutes_reg == '0 && energy_reg == '0 && steps_reg == '0 && !goal,
                   "clear item left totals set")

endmodule

`default_nettype wire

// File: tb/tb_activity_totals_accumulator_core.sv
// ----------------------------------------------------------------------------
// tb_activity_totals_accumulator_core
// Streams tick and clear items through the accumulator under random stalls
// on both channels and checks every totals result against a cycle-free
// predictor of steps, distance, active minutes, energy and goal_check.
// Profiles are set over APB between phases, extremes included.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_activity_totals_accumulator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;
  localparam int   CYCLE_LIMIT = 1000000;

  typedef struct {
    logic                        func;
    logic [atc_pkg::STEPS_W-1:0] steps;
    logic                        usb;
  } tick_item_t;

  typedef struct {
    logic [atc_pkg::STEPS_W-1:0] shown_steps;
    logic [atc_pkg::DIST_W-1:0]  distance;
    logic [atc_pkg::TOTAL_W-1:0] active_minutes;
    logic [atc_pkg::TOTAL_W-1:0] energy;
    logic                        goal_check;
  } totals_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [atc_pkg::ADDR_W-1:0] paddr;
  logic [atc_pkg::DATA_W-1:0] pwdata;
  logic [atc_pkg::DATA_W-1:0] prdata;
  logic pready;

  atc_req_if req_ch();
  atc_rsp_if rsp_ch();

  activity_totals_accumulator_core dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // profile mirror
  logic [atc_pkg::USER_W-1:0] cfg_height, cfg_weight, cfg_age;
  logic                       cfg_sex, cfg_basal;

  // predicted tracking state and totals
  logic [atc_pkg::STEPS_W-1:0] last_tick_steps, last_pair_steps, last_minute_steps;
  int unsigned                 tick_in_minute;
  logic                        pair_phase;
  int unsigned                 active_seconds;
  logic [atc_pkg::STEPS_W-1:0] shown_r;
  logic [atc_pkg::DIST_W-1:0]  dist_r;
  logic [atc_pkg::TOTAL_W-1:0] minutes_r, energy_r;

  tick_item_t pending_ticks[$];
  totals_t    expected_totals[$];
  int         in_flight;
  int         fail_count;
  int         cycle_count;
  int         send_gap;
  int         hold_left;
  int         idle_pct;
  logic       long_hold_due;
  logic [atc_pkg::STEPS_W-1:0] walk_steps;

  always #4 clk = ~clk;

  task automatic flag(input string msg);
    if (fail_count < 40) $display("ERROR @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic int pick_pause();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic totals_t advance_totals(input tick_item_t it);
    totals_t res;
    logic changed;
    logic [31:0] stride, delta, tier, base, kcal;
    res.goal_check = 1'b0;
    if (it.func == FUNC_CLEAR) begin
      last_tick_steps = '0;
      last_pair_steps = '0;
      last_minute_steps = '0;
      tick_in_minute = 0;
      pair_phase = 1'b0;
      active_seconds = 0;
      shown_r = '0;
      dist_r = '0;
      minutes_r = '0;
      energy_r = '0;
    end else begin
      changed = (it.steps != last_tick_steps);
      last_tick_steps = it.steps;
      tick_in_minute++;
      pair_phase = ~pair_phase;
      if (changed) begin
        stride = (32'(cfg_height) * (cfg_sex ? 32'd413 : 32'd415)) / 32'd1000;
        shown_r = it.steps;
        dist_r = atc_pkg::DIST_W'((32'(it.steps) * stride) / 32'd100);
        res.goal_check = 1'b1;
      end
      if (!pair_phase) begin
        if (it.steps > last_pair_steps) begin
          active_seconds += 20;
          if (active_seconds >= 60) begin
            active_seconds = 0;
            minutes_r++;
            res.goal_check = 1'b1;
          end
        end
        last_pair_steps = it.steps;
      end
      if (tick_in_minute >= atc_pkg::TICKS_PER_MINUTE) begin
        if (it.steps > last_minute_steps) begin
          delta = 32'(it.steps - last_minute_steps);
          if (delta < 40) tier = 1;
          else if (delta < 80) tier = 15;
          else if (delta < 100) tier = 20;
          else if (delta < 120) tier = 35;
          else if (delta < 140) tier = 55;
          else if (delta < 160) tier = 80;
          else if (delta < 180) tier = 110;
          else tier = 140;
          energy_r += (32'(cfg_weight) * 32'd176 * tier) / 32'd10000;
          res.goal_check = 1'b1;
        end
        if (cfg_basal && !it.usb) begin
          // unsigned wrap of a negative intermediate lands on the cap
          base = 32'd889 * cfg_height + 32'd14 * cfg_weight - 32'd699 * cfg_age + 32'd1414;
          kcal = 32'd5 * ((base >> 10) - 32'd23 * cfg_sex);
          energy_r += (kcal > 32'd3700) ? 32'd3700 : kcal;
          res.goal_check = 1'b1;
        end
        last_minute_steps = it.steps;
        tick_in_minute = 0;
      end
    end
    res.shown_steps = shown_r;
    res.distance = dist_r;
    res.active_minutes = minutes_r;
    res.energy = energy_r;
    return res;
  endfunction

  // request driver
  always @(posedge clk) begin
    tick_item_t it;
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        it.func = req_ch.func;
        it.steps = req_ch.step_total;
        it.usb = req_ch.usb_attached;
        expected_totals.push_back(advance_totals(it));
        in_flight--;
      end
      if (!(req_ch.valid && !req_ch.ready)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          it = pending_ticks.pop_front();
          in_flight++;
          req_ch.valid <= 1'b1;
          req_ch.func <= it.func;
          req_ch.step_total <= it.steps;
          req_ch.usb_attached <= it.usb;
          send_gap <= ($urandom_range(0, 99) < idle_pct) ? pick_pause() : 0;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    totals_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_totals.size() == 0) begin
          flag("result with no item pending");
        end else begin
          want = expected_totals.pop_front();
          if (rsp_ch.shown_steps !== want.shown_steps)
            flag($sformatf("shown_steps got %0d want %0d", rsp_ch.shown_steps,
                           want.shown_steps));
          if (rsp_ch.distance !== want.distance)
            flag($sformatf("distance got %0d want %0d", rsp_ch.distance, want.distance));
          if (rsp_ch.active_minutes !== want.active_minutes)
            flag($sformatf("active_minutes got %0d want %0d", rsp_ch.active_minutes,
                           want.active_minutes));
          if (rsp_ch.energy !== want.energy)
            flag($sformatf("energy got %0d want %0d", rsp_ch.energy, want.energy));
          if (rsp_ch.goal_check !== want.goal_check)
            flag($sformatf("goal_check got %0b want %0b", rsp_ch.goal_check,
                           want.goal_check));
        end
      end
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        hold_left <= 400;
        rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        hold_left <= pick_pause() - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input logic [atc_pkg::REG_IDX_W-1:0] idx,
                           input logic [atc_pkg::DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      atc_pkg::REG_HEIGHT:   cfg_height = value[atc_pkg::USER_W-1:0];
      atc_pkg::REG_WEIGHT:   cfg_weight = value[atc_pkg::USER_W-1:0];
      atc_pkg::REG_AGE:      cfg_age = value[atc_pkg::USER_W-1:0];
      atc_pkg::REG_SEX:      cfg_sex = value[0];
      atc_pkg::REG_BASAL_EN: cfg_basal = value[0];
      default: ;
    endcase
  endtask

  task automatic set_profile(input int h, input int w, input int a, input int s, input int b);
    write_reg(atc_pkg::REG_HEIGHT, h);
    write_reg(atc_pkg::REG_WEIGHT, w);
    write_reg(atc_pkg::REG_AGE, a);
    write_reg(atc_pkg::REG_SEX, s);
    write_reg(atc_pkg::REG_BASAL_EN, b);
  endtask

  task automatic push_tick(input logic func, input logic [atc_pkg::STEPS_W-1:0] steps,
                           input logic usb);
    tick_item_t it;
    it.func = func;
    it.steps = steps;
    it.usb = usb;
    pending_ticks.push_back(it);
  endtask

  // mostly a rising pedometer total, with jumps, falls, saturation and clears
  task automatic queue_activity(input int count);
    int pick;
    logic [atc_pkg::STEPS_W-1:0] step;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        push_tick(FUNC_CLEAR, atc_pkg::STEPS_W'($urandom), 1'($urandom_range(0, 1)));
        walk_steps = '0;
      end else begin
        if (pick < 5) begin
          walk_steps = atc_pkg::STEPS_W'($urandom);
        end else if (pick < 7) begin
          walk_steps = walk_steps - atc_pkg::STEPS_W'($urandom_range(0, walk_steps));
        end else if (pick < 9) begin
          walk_steps = 24'hFFFFFF - atc_pkg::STEPS_W'($urandom_range(0, 150));
        end else if ($urandom_range(0, 3) != 0) begin
          step = atc_pkg::STEPS_W'($urandom_range(0, 50));
          walk_steps = (walk_steps > 24'hFFFFFF - step) ? 24'hFFFFFF : walk_steps + step;
        end
        push_tick(FUNC_TICK, walk_steps, $urandom_range(0, 4) == 0);
      end
    end
  endtask

  task automatic drain();
    while (pending_ticks.size() != 0 || in_flight != 0 || expected_totals.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.func = FUNC_TICK;
    req_ch.step_total = '0;
    req_ch.usb_attached = 1'b0;
    rsp_ch.ready = 1'b0;
    in_flight = 0;
    fail_count = 0;
    cycle_count = 0;
    send_gap = 0;
    hold_left = 0;
    idle_pct = 15;
    long_hold_due = 1'b0;
    walk_steps = '0;
    cfg_height = '0;
    cfg_weight = '0;
    cfg_age = '0;
    cfg_sex = 1'b0;
    cfg_basal = 1'b0;
    last_tick_steps = '0;
    last_pair_steps = '0;
    last_minute_steps = '0;
    tick_in_minute = 0;
    pair_phase = 1'b0;
    active_seconds = 0;
    shown_r = '0;
    dist_r = '0;
    minutes_r = '0;
    energy_r = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    set_profile(170, 65, 40, 1, 1);
    push_tick(FUNC_TICK, 24'd0, 1'b0);          // unchanged total, no goal
    push_tick(FUNC_TICK, 24'd39, 1'b0);
    push_tick(FUNC_TICK, 24'd39, 1'b0);
    push_tick(FUNC_TICK, 24'd40, 1'b0);
    push_tick(FUNC_TICK, 24'd80, 1'b0);
    push_tick(FUNC_TICK, 24'd180, 1'b0);        // top tier plus basal
    push_tick(FUNC_TICK, 24'd179, 1'b0);        // falling total
    push_tick(FUNC_TICK, 24'hFFFFFF, 1'b0);
    push_tick(FUNC_TICK, 24'hFFFFFF, 1'b0);
    push_tick(FUNC_TICK, 24'hFFFFFE, 1'b1);
    push_tick(FUNC_TICK, 24'd0, 1'b0);
    push_tick(FUNC_TICK, 24'd0, 1'b1);          // minute end, usb blocks basal
    push_tick(FUNC_CLEAR, 24'hFFFFFF, 1'b1);
    push_tick(FUNC_CLEAR, 24'd0, 1'b0);
    push_tick(FUNC_TICK, 24'd20, 1'b0);
    push_tick(FUNC_TICK, 24'd40, 1'b1);
    push_tick(FUNC_TICK, 24'd60, 1'b0);
    push_tick(FUNC_TICK, 24'd80, 1'b1);
    push_tick(FUNC_TICK, 24'd100, 1'b0);
    push_tick(FUNC_TICK, 24'd139, 1'b1);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_profile(0, 0, 0, 0, 0);
        1: set_profile(255, 255, 255, 1, 1);
        2: set_profile(0, 0, 255, 1, 1);
        3: set_profile(255, 255, 0, 0, 1);
        default: set_profile($urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255), $urandom_range(0, 1),
                             int'($urandom_range(0, 3) != 0));
      endcase
      idle_pct = (phase == 0) ? 0 : (phase == 2) ? 40 : 15;
      if (phase == 3) long_hold_due = 1'b1;
      queue_activity(240);
      drain();
    end

    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
